[design/cascaded_attitude_pi_stabilizer_core_macros.svh]
// Assertion macros for the attitude stabilizer core.
`ifndef CASCADED_ATTITUDE_PI_STABILIZER_CORE_MACROS_SVH
`define CASCADED_ATTITUDE_PI_STABILIZER_CORE_MACROS_SVH

`ifndef SYNTH
`define CAP_ASSERT(lbl, clk, rst, p, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) p) else $error(msg);
`define CAP_NEVER(lbl, clk, rst, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(c)) else $error(msg);
`else
`define CAP_ASSERT(lbl, clk, rst, p, msg)
`define CAP_NEVER(lbl, clk, rst, c, msg)
`endif

`endif

[design/cap_pkg.sv]
`default_nettype none
package cap_pkg;

  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 17;
  localparam int V_W       = 25;
  localparam int ACC_W     = 40;
  localparam int SUM_W     = 57;
  localparam int MUL_STEPS = 16;
  localparam int CNT_W     = 4;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_SETPOINT_ROLL   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SETPOINT_PITCH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_POS_GAIN_ROLL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_POS_GAIN_PITCH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_RATE_GAIN_ROLL  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RATE_GAIN_PITCH = 3'd5;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN       = 3'd6;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN   = 3'd7;

  localparam logic [DATA_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd77, 16'd435, 16'd3840, 16'd3840, 16'd384, 16'd384, 16'd256, 16'd0
  };

  typedef struct packed {
    logic [DATA_W-1:0] setpoint;
    logic [GAIN_W-1:0] pos_gain;
    logic [GAIN_W-1:0] rate_gain;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
  } cap_gains_t;

  typedef struct packed {
    logic load;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

endpackage
`default_nettype wire

[design/cap_intf.sv]
`default_nettype none
interface cap_in_if;
  logic        valid;
  logic        ready;
  logic        axis;
  logic [15:0] angle;
  logic [15:0] rate;

  modport source (output valid, output axis, output angle, output rate, input ready);
  modport sink (input valid, input axis, input angle, input rate, output ready);
endinterface

interface cap_out_if;
  logic        valid;
  logic        ready;
  logic        axis_out;
  logic [15:0] drive;

  modport source (output valid, output axis_out, output drive, input ready);
  modport sink (input valid, input axis_out, input drive, output ready);
endinterface
`default_nettype wire

[design/cascaded_attitude_pi_stabilizer_core.sv]
// Two-axis cascaded PI attitude stabilizer with rate feedback.
// sample channel: valid/ready with axis (0 roll, 1 pitch), angle and rate,
// all signed Q8.8. result channel: valid/ready with axis_out and drive, the
// clamped Q8.8 thruster command. One result per sample, in order.
// The user must write gains and setpoints through cfg_we/cfg_index/cfg_data
// while idle; the block itself does not enforce it. A sample is taken only
// when the sequencer is idle. Its work runs four passes of one shared
// bit-serial multiplier (angle error, then proportional, integral and rate
// terms), with the integrator state update and a load step before each later
// pass; the next sample is taken once the drive is in the output register.
// The result sits in an output register; the next sample is accepted while it
// waits. If the receiver still stalls when the next drive is finished, the
// sequencer holds that drive until the register frees.
// A synchronous reset loads the default gains and setpoints, clears both axis
// integrators and previous errors, and empties the output register.
`default_nettype none
`include "cascaded_attitude_pi_stabilizer_core_macros.svh"
module cascaded_attitude_pi_stabilizer_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  cap_in_if.sink                          sample,
  cap_out_if.source                       result,
  input  wire logic                       cfg_we,
  input  wire logic [cap_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [cap_pkg::DATA_W-1:0] cfg_data
);
  import cap_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_ERR   = 4'd1;
  localparam logic [3:0] S_INTEG     = 4'd2;
  localparam logic [3:0] S_MUL_PROP  = 4'd3;
  localparam logic [3:0] S_LOAD_INT  = 4'd4;
  localparam logic [3:0] S_MUL_INT   = 4'd5;
  localparam logic [3:0] S_LOAD_RATE = 4'd6;
  localparam logic [3:0] S_MUL_RATE  = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  localparam int Q_W = SUM_W - 8;
  localparam logic signed [Q_W-1:0] DRIVE_MAX = Q_W'(32512);
  localparam logic signed [Q_W-1:0] DRIVE_MIN = -Q_W'(32768);

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic              axis_r;
  logic [DATA_W-1:0] rate_r;
  logic [ACC_W-1:0]  acc_cur;
  logic [V_W-1:0]    prev [2];
  logic [ACC_W-1:0]  acc_st [2];
  logic              out_valid;
  logic [DATA_W-1:0] drive_r;
  logic              axis_out_r;

  cap_gains_t        gains;
  mac_ctl_t          mac_ctl;
  mac_stat_t         mac_stat;
  logic [SUM_W-1:0]  mac_operand;
  logic [GAIN_W-1:0] mac_gain;
  logic [SUM_W-1:0]  mac_sum;

  logic              accept;
  logic              sel_axis;
  logic              out_free;
  logic [ERR_W-1:0]  err;
  logic [ERR_W-1:0]  neg_rate;
  logic [V_W-1:0]    v;
  logic [V_W:0]      tsum;
  logic [V_W-1:0]    t;
  logic [ACC_W:0]    acc_wide;
  logic [ACC_W-1:0]  acc_new;
  logic signed [Q_W-1:0] q;
  logic [DATA_W-1:0] drive_clamped;

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign sel_axis     = (state == S_IDLE) ? sample.axis : axis_r;
  assign out_free     = !out_valid || result.ready;

  cap_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .axis  (sel_axis),
    .gains (gains)
  );

  cap_serial_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .operand (mac_operand),
    .gain    (mac_gain),
    .stat    (mac_stat),
    .sum     (mac_sum)
  );

  assign err      = {gains.setpoint[DATA_W-1], gains.setpoint}
                  - {sample.angle[DATA_W-1], sample.angle};
  assign neg_rate = ERR_W'(0) - {rate_r[DATA_W-1], rate_r};

  // trapezoid term and saturating integrator
  assign v        = mac_sum[V_W+7:8];
  assign tsum     = {v[V_W-1], v} + {prev[axis_r][V_W-1], prev[axis_r]};
  assign t        = tsum[V_W:1];
  assign acc_wide = {acc_st[axis_r][ACC_W-1], acc_st[axis_r]}
                  + {{(ACC_W - V_W + 1){t[V_W-1]}}, t};

  always_comb begin
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      acc_new = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_wide[ACC_W-1:0];
    end
  end

  assign q = $signed(mac_sum[SUM_W-1:8]);

  always_comb begin
    if (q > DRIVE_MAX) begin
      drive_clamped = DRIVE_MAX[DATA_W-1:0];
    end else if (q < DRIVE_MIN) begin
      drive_clamped = DRIVE_MIN[DATA_W-1:0];
    end else begin
      drive_clamped = q[DATA_W-1:0];
    end
  end

  always_comb begin
    mac_ctl     = '0;
    mac_operand = '0;
    mac_gain    = '0;
    unique case (state)
      S_IDLE: begin
        mac_ctl.load  = accept;
        mac_ctl.clear = 1'b1;
        mac_operand   = {{(SUM_W - ERR_W){err[ERR_W-1]}}, err};
        mac_gain      = gains.pos_gain;
      end
      S_INTEG: begin
        mac_ctl.load  = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_operand   = {{(SUM_W - V_W){v[V_W-1]}}, v};
        mac_gain      = gains.prop_gain;
      end
      S_LOAD_INT: begin
        mac_ctl.load  = 1'b1;
        mac_operand   = {{(SUM_W - ACC_W){acc_cur[ACC_W-1]}}, acc_cur};
        mac_gain      = gains.integral_gain;
      end
      S_LOAD_RATE: begin
        mac_ctl.load  = 1'b1;
        mac_operand   = {{(SUM_W - ERR_W){neg_rate[ERR_W-1]}}, neg_rate};
        mac_gain      = gains.rate_gain;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (accept) state_next = S_MUL_ERR;
      S_MUL_ERR:   if (mac_stat.done) state_next = S_INTEG;
      S_INTEG:     state_next = S_MUL_PROP;
      S_MUL_PROP:  if (mac_stat.done) state_next = S_LOAD_INT;
      S_LOAD_INT:  state_next = S_MUL_INT;
      S_MUL_INT:   if (mac_stat.done) state_next = S_LOAD_RATE;
      S_LOAD_RATE: state_next = S_MUL_RATE;
      S_MUL_RATE:  if (mac_stat.done) state_next = S_DONE;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        prev[i]   <= '0;
        acc_st[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_INTEG) begin
        prev[axis_r]   <= v;
        acc_st[axis_r] <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      axis_r <= sample.axis;
      rate_r <= sample.rate;
    end
    if (state == S_INTEG) begin
      acc_cur <= acc_new;
    end
    if (state == S_DONE && out_free) begin
      drive_r    <= drive_clamped;
      axis_out_r <= axis_r;
    end
  end

  assign result.valid    = out_valid;
  assign result.drive    = drive_r;
  assign result.axis_out = axis_out_r;

  `CAP_ASSERT(a_accept_starts, clk, rst, (sample.valid && sample.ready) |=> (state == S_MUL_ERR && mac_stat.busy), "transaction accepted without starting the error multiply")
  `CAP_NEVER(a_load_busy, clk, rst, mac_ctl.load && mac_stat.busy, "multiplier loaded while busy")
  `CAP_ASSERT(a_out_from_done, clk, rst, $rose(result.valid) |-> ($past(state) == S_DONE), "result valid raised outside the done step")
  `CAP_ASSERT(a_done_in_wait, clk, rst, mac_stat.done |-> (state == S_MUL_ERR || state == S_MUL_PROP || state == S_MUL_INT || state == S_MUL_RATE), "multiplier finished outside a wait state")

endmodule
`default_nettype wire

[design/cap_cfg_regs.sv]
`default_nettype none
module cap_cfg_regs (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [cap_pkg::IDX_W-1:0] index,
  input  wire logic [cap_pkg::DATA_W-1:0] data,
  input  wire logic                     axis,
  output cap_pkg::cap_gains_t            gains
);
  import cap_pkg::*;

  logic [DATA_W-1:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= REG_RESET[i];
      end
    end else if (we) begin
      regs[index] <= data;
    end
  end

  // select the per-axis set
  always_comb begin
    gains.setpoint      = axis ? regs[REG_SETPOINT_PITCH] : regs[REG_SETPOINT_ROLL];
    gains.pos_gain      = axis ? regs[REG_POS_GAIN_PITCH] : regs[REG_POS_GAIN_ROLL];
    gains.rate_gain     = axis ? regs[REG_RATE_GAIN_PITCH] : regs[REG_RATE_GAIN_ROLL];
    gains.prop_gain     = regs[REG_PROP_GAIN];
    gains.integral_gain = regs[REG_INTEGRAL_GAIN];
  end

endmodule
`default_nettype wire

[design/cap_serial_mac.sv]
`default_nettype none
module cap_serial_mac (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cap_pkg::mac_ctl_t         ctl,
  input  wire logic [cap_pkg::SUM_W-1:0]  operand,
  input  wire logic [cap_pkg::GAIN_W-1:0] gain,
  output cap_pkg::mac_stat_t             stat,
  output logic [cap_pkg::SUM_W-1:0]      sum
);
  import cap_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_STEPS - 1);

  logic [SUM_W-1:0]  m;
  logic [GAIN_W-1:0] g;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // one gain bit per cycle, sign bit weighs negative
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      m <= operand;
      g <= gain;
      if (ctl.clear) begin
        sum <= '0;
      end
    end else if (busy) begin
      m <= m << 1;
      g <= g >> 1;
      if (g[0]) begin
        sum <= (cnt == LAST) ? sum - m : sum + m;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (cnt == LAST);

endmodule
`default_nettype wire

[verif/tb_cascaded_attitude_pi_stabilizer_core.sv]
`timescale 1ns / 100ps
module tb_cascaded_attitude_pi_stabilizer_core;
  import cap_pkg::*;

  localparam int     CYCLE_LIMIT = 1000000;
  localparam longint INTEG_MAX   = 64'sd549755813887;
  localparam longint INTEG_MIN   = -INTEG_MAX - 1;
  localparam longint DRIVE_MAX   = 32512;
  localparam longint DRIVE_MIN   = -32768;

  typedef struct {
    logic        axis;
    logic [15:0] drive;
  } drive_exp_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  cap_in_if  smp ();
  cap_out_if res ();

  cascaded_attitude_pi_stabilizer_core dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [15:0] cfg_shadow [NUM_REGS];
  logic [15:0] cfg_next [NUM_REGS];
  longint      prev_err [2];
  longint      integ_acc [2];
  drive_exp_t  pending_drives [$];

  int cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int drives_checked = 0;
  int settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("[cascaded_attitude_pi_stabilizer_core] ERROR");
    $finish;
  end

  function automatic longint sx16(logic [15:0] x);
    return longint'($signed(x));
  endfunction

  function automatic drive_exp_t predict_drive(logic ax, logic [15:0] ang, logic [15:0] rt);
    longint     sp, pg, rg, kp, ki, err_v, acc, sum, drv;
    drive_exp_t exp_d;
    sp = sx16(cfg_shadow[ax ? REG_SETPOINT_PITCH : REG_SETPOINT_ROLL]);
    pg = sx16(cfg_shadow[ax ? REG_POS_GAIN_PITCH : REG_POS_GAIN_ROLL]);
    rg = sx16(cfg_shadow[ax ? REG_RATE_GAIN_PITCH : REG_RATE_GAIN_ROLL]);
    kp = sx16(cfg_shadow[REG_PROP_GAIN]);
    ki = sx16(cfg_shadow[REG_INTEGRAL_GAIN]);
    err_v = ((sp - sx16(ang)) * pg) >>> 8;
    acc = integ_acc[ax] + ((err_v + prev_err[ax]) >>> 1);
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ_acc[ax] = acc;
    prev_err[ax] = err_v;
    sum = err_v * kp + acc * ki - sx16(rt) * rg;
    drv = sum >>> 8;
    if (drv > DRIVE_MAX) drv = DRIVE_MAX;
    if (drv < DRIVE_MIN) drv = DRIVE_MIN;
    exp_d.axis = ax;
    exp_d.drive = drv[15:0];
    return exp_d;
  endfunction

  function automatic logic [15:0] rand_setting();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 1023)) - 16'd512;
    endcase
  endfunction

  // Receiver: stall at random or for a requested hold, check each transaction.
  initial begin
    drive_exp_t exp_d;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        if (pending_drives.size() == 0) begin
          mismatches++;
          $error("unexpected drive: axis_out %0d drive %0d", res.axis_out,
                 $signed(res.drive));
        end else begin
          exp_d = pending_drives.pop_front();
          drives_checked++;
          if (res.axis_out !== exp_d.axis) begin
            mismatches++;
            $error("axis_out: expected %0d, got %0d", exp_d.axis, res.axis_out);
          end
          if (res.drive !== exp_d.drive) begin
            mismatches++;
            $error("drive: expected %0d, got %0d", $signed(exp_d.drive), $signed(res.drive));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic apply_reset();
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_REGS; i++) cfg_shadow[i] = REG_RESET[i];
    for (int a = 0; a < 2; a++) begin
      prev_err[a] = 0;
      integ_acc[a] = 0;
    end
    @(posedge clk);
  endtask

  task automatic load_settings();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= cfg_next[i];
      @(posedge clk);
      cfg_shadow[i] = cfg_next[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic offer_sample(input logic ax, input logic [15:0] ang, input logic [15:0] rt);
    while ($urandom_range(99) < src_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.axis <= ax;
    smp.angle <= ang;
    smp.rate <= rt;
    do @(posedge clk); while (!smp.ready);
    pending_drives.push_back(predict_drive(ax, ang, rt));
    samples_sent++;
  endtask

  task automatic wait_drained();
    smp.valid <= 1'b0;
    do @(posedge clk); while (pending_drives.size() != 0);
  endtask

  task automatic send_random_samples(input int count);
    logic        ax;
    logic [15:0] ang, rt, sp;
    int          run_left;
    run_left = 0;
    ax = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        ax = 1'($urandom_range(1));
        run_left = $urandom_range(1, 8);
      end
      run_left--;
      sp = cfg_shadow[ax ? REG_SETPOINT_PITCH : REG_SETPOINT_ROLL];
      if ($urandom_range(4) == 0) begin
        ang = 16'($urandom);
        rt = 16'($urandom);
      end else begin
        ang = sp + 16'($urandom_range(0, 4095)) - 16'd2048;
        rt = 16'($urandom_range(0, 8191)) - 16'd4096;
      end
      offer_sample(ax, ang, rt);
    end
  endtask

  task automatic test_reset_settings();
    offer_sample(1'b0, 16'h0000, 16'h0000);
    offer_sample(1'b1, 16'h0000, 16'h0000);
    offer_sample(1'b0, 16'h7FFF, 16'h8000);
    offer_sample(1'b1, 16'h8000, 16'h7FFF);
    offer_sample(1'b0, 16'd77, 16'h0000);
    offer_sample(1'b1, 16'd435, 16'h0001);
    wait_drained();
  endtask

  task automatic test_extreme_settings();
    cfg_next[REG_SETPOINT_ROLL]   = 16'h7FFF;
    cfg_next[REG_SETPOINT_PITCH]  = 16'h7FFF;
    cfg_next[REG_POS_GAIN_ROLL]   = 16'h8000;
    cfg_next[REG_POS_GAIN_PITCH]  = 16'h8000;
    cfg_next[REG_RATE_GAIN_ROLL]  = 16'h7FFF;
    cfg_next[REG_RATE_GAIN_PITCH] = 16'h7FFF;
    cfg_next[REG_PROP_GAIN]       = 16'h7FFF;
    cfg_next[REG_INTEGRAL_GAIN]   = 16'h7FFF;
    load_settings();
    offer_sample(1'b0, 16'h8000, 16'h8000);
    offer_sample(1'b1, 16'h8000, 16'h7FFF);
    offer_sample(1'b0, 16'h7FFF, 16'h0000);
    offer_sample(1'b1, 16'h0000, 16'h8000);
    offer_sample(1'b0, 16'h8000, 16'h8000);
    wait_drained();

    cfg_next[REG_SETPOINT_ROLL]   = 16'h8000;
    cfg_next[REG_SETPOINT_PITCH]  = 16'h8000;
    cfg_next[REG_POS_GAIN_ROLL]   = 16'h7FFF;
    cfg_next[REG_POS_GAIN_PITCH]  = 16'h7FFF;
    cfg_next[REG_RATE_GAIN_ROLL]  = 16'h8000;
    cfg_next[REG_RATE_GAIN_PITCH] = 16'h8000;
    cfg_next[REG_PROP_GAIN]       = 16'h8000;
    cfg_next[REG_INTEGRAL_GAIN]   = 16'h8000;
    load_settings();
    offer_sample(1'b0, 16'h7FFF, 16'h7FFF);
    offer_sample(1'b1, 16'h7FFF, 16'h8000);
    offer_sample(1'b0, 16'h8000, 16'hFFFF);
    offer_sample(1'b1, 16'h0001, 16'h7FFF);
    offer_sample(1'b1, 16'h7FFF, 16'h7FFF);
    wait_drained();

    for (int i = 0; i < NUM_REGS; i++) cfg_next[i] = 16'h0000;
    load_settings();
    offer_sample(1'b0, 16'hFFFF, 16'hFFFF);
    offer_sample(1'b1, 16'h5555, 16'hAAAA);
    wait_drained();

    // Integral path alone: odd trapezoid sums round toward minus infinity.
    cfg_next[REG_POS_GAIN_ROLL] = 16'd256;
    cfg_next[REG_INTEGRAL_GAIN] = 16'd1;
    load_settings();
    offer_sample(1'b0, 16'd3, 16'h0000);
    offer_sample(1'b0, 16'hFFFE, 16'h0000);
    offer_sample(1'b0, 16'd7, 16'h0000);
    offer_sample(1'b0, 16'hFFF9, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_next[i] = rand_setting();
      if ($urandom_range(3) != 0)
        cfg_next[REG_INTEGRAL_GAIN] = 16'($urandom_range(0, 63)) - 16'd32;
      load_settings();
      send_random_samples(100);
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_left = 400;
    send_random_samples(10);
    wait_drained();
  endtask

  task automatic test_pause_and_resume();
    src_idle_pct = 34;
    snk_idle_pct = 34;
    send_random_samples(8);
    wait_drained();
    send_random_samples(8);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.axis = 1'b0;
    smp.angle = '0;
    smp.rate = '0;
    apply_reset();

    test_reset_settings();
    test_extreme_settings();
    test_random_traffic(34, 74);
    test_random_traffic(74, 34);
    test_random_traffic(0, 0);
    test_output_backpressure();
    test_pause_and_resume();

    wait_drained();
    repeat (80) @(posedge clk);
    $display("Covered %0d samples on both axes under %0d register settings,",
             samples_sent, settings_used);
    $display("with %0d drives checked in %0d cycles.", drives_checked, cycles);
    if (mismatches == 0) begin
      $display("[cascaded_attitude_pi_stabilizer_core] OK");
    end else begin
      $display("[cascaded_attitude_pi_stabilizer_core] ERROR");
    end
    $finish;
  end
endmodule
